>>> rtl/core/adfgvx_pkg.sv
// ----------------------------------------------------------------------------
// adfgvx_pkg
// Shared constants, types and helper functions for the ADFGVX encoder.
// ----------------------------------------------------------------------------
package adfgvx_pkg;

    localparam int GRID_SIDE = 6;
    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int LETTERS   = 26;
    localparam int CELL_W    = $clog2(CELLS);
    localparam int POS_W     = $clog2(GRID_SIDE);
    localparam int SYM_W     = 8;
    localparam int LETTERS_W = SYM_W * GRID_SIDE;
    localparam int ORDER_W   = POS_W * GRID_SIDE;
    localparam int ROWCNT_W  = POS_W;

    // input modes
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_KEY   = 2'd1;
    localparam logic [1:0] MODE_SEAL  = 2'd2;
    localparam logic [1:0] MODE_MSG   = 2'd3;

    // configuration register indexes
    localparam logic CFG_SYMBOL_LETTERS = 1'b0;
    localparam logic CFG_COLUMN_ORDER   = 1'b1;

    localparam logic [LETTERS_W-1:0] SYMBOL_LETTERS_RST = 48'h475856414644;
    localparam logic [ORDER_W-1:0]   COLUMN_ORDER_RST   = 18'h21A13;

    typedef struct packed {
        logic              hit;
        logic [CELL_W-1:0] idx;
    } t_class;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic key_write;
        logic seal_step;
        logic lookup;
        logic row_store;
        logic emit_beat;
        logic err_beat;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic msg_hit;
        logic seal_last;
        logic row_last;
        logic beat_last;
        logic out_free;
    } t_dp_stat;

    // letters A-Z map to 0-25, digits 0-9 to 26-35
    function automatic t_class class_of(input logic [SYM_W-1:0] ch);
        t_class c;
        c.hit = 1'b0;
        c.idx = '0;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            c.hit = 1'b1;
            c.idx = CELL_W'(ch - 8'h41);
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            c.hit = 1'b1;
            c.idx = CELL_W'(ch - 8'h30) + CELL_W'(LETTERS);
        end
        return c;
    endfunction

    function automatic logic [SYM_W-1:0] to_upper(input logic [SYM_W-1:0] ch);
        logic [SYM_W-1:0] u;
        u = ch;
        if (ch >= 8'h61 && ch <= 8'h7A) begin
            u = ch - 8'h20;
        end
        return u;
    endfunction

    function automatic logic [POS_W-1:0] grid_row(input logic [CELL_W-1:0] k);
        logic [POS_W-1:0] row;
        row = '0;
        for (int r = 1; r < GRID_SIDE; r++) begin
            if (k >= CELL_W'(r * GRID_SIDE)) begin
                row = POS_W'(r);
            end
        end
        return row;
    endfunction

    function automatic logic [POS_W-1:0] grid_col(input logic [CELL_W-1:0] k);
        logic [CELL_W-1:0] base;
        logic [CELL_W-1:0] rem;
        base = CELL_W'(grid_row(k)) * CELL_W'(GRID_SIDE);
        rem  = k - base;
        return rem[POS_W-1:0];
    endfunction

endpackage

>>> rtl/core/adfgvx_ctrl.sv
// ----------------------------------------------------------------------------
// adfgvx_ctrl
// Sequencer for the ADFGVX encoder: takes input beats, steps the seal sweep,
// the lookup, the six-beat row emission and the error beat.
// ----------------------------------------------------------------------------
module adfgvx_ctrl
    import adfgvx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_mode,
    input  t_dp_stat   i_stat,
    output logic       o_in_stall,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEAL,
        S_LOOK,
        S_EMIT,
        S_ERR
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        MODE_CLEAR: o_cmd.clear = 1'b1;
                        MODE_KEY:   o_cmd.key_write = 1'b1;
                        MODE_SEAL:  n_state = S_SEAL;
                        MODE_MSG: begin
                            if (i_stat.msg_hit) begin
                                o_cmd.lookup = 1'b1;
                                n_state      = S_LOOK;
                            end else begin
                                n_state = S_ERR;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SEAL: begin
                o_cmd.seal_step = 1'b1;
                if (i_stat.seal_last) begin
                    n_state = S_IDLE;
                end
            end
            S_LOOK: begin
                o_cmd.row_store = 1'b1;
                n_state = i_stat.row_last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                o_cmd.emit_beat = i_stat.out_free;
                if (i_stat.out_free && i_stat.beat_last) begin
                    n_state = S_IDLE;
                end
            end
            S_ERR: begin
                o_cmd.err_beat = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/core/adfgvx_dp.sv
// ----------------------------------------------------------------------------
// adfgvx_dp
// Datapath: seen flags, square position map, fill count, row buffer and the
// output register.
// ----------------------------------------------------------------------------
module adfgvx_dp
    import adfgvx_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic [SYM_W-1:0]     i_char_code,
    input  logic [LETTERS_W-1:0] i_symbol_letters,
    input  logic [ORDER_W-1:0]   i_column_order,
    input  logic                 i_out_stall,
    output t_dp_stat             o_stat,
    output logic                 o_out_valid,
    output logic [SYM_W-1:0]     o_symbol,
    output logic                 o_last,
    output logic                 o_bad_char
);

    // square kept as its inverse: grid position of each character class
    logic [CELL_W-1:0]   r_map [CELLS];
    logic [CELL_W-1:0]   r_map_q;
    logic [CELLS-1:0]    r_seen;
    logic [CELL_W-1:0]   r_fill;
    logic                r_sealed;
    logic [CELL_W-1:0]   r_seal_idx;
    logic [POS_W-1:0]    r_row_buf [GRID_SIDE];
    logic [ROWCNT_W-1:0] r_row_count;
    logic [POS_W-1:0]    r_beat;
    logic                r_out_valid;
    logic [SYM_W-1:0]    r_symbol;
    logic                r_last;
    logic                r_bad_char;

    t_class              key_cls;
    t_class              msg_cls;
    logic                key_new;
    logic                seal_new;
    logic                map_we;
    logic [CELL_W-1:0]   map_waddr;
    logic [POS_W-1:0]    src;
    logic [POS_W-1:0]    sym_idx;
    logic [SYM_W-1:0]    emit_sym;
    logic                out_free;

    assign key_cls  = class_of(to_upper(i_char_code));
    assign msg_cls  = class_of(i_char_code);
    assign key_new  = i_cmd.key_write && key_cls.hit && !r_seen[key_cls.idx];
    assign seal_new = i_cmd.seal_step && !r_seen[r_seal_idx];
    assign map_we    = key_new || seal_new;
    assign map_waddr = key_new ? key_cls.idx : r_seal_idx;

    assign out_free = !r_out_valid || !i_out_stall;

    assign o_stat.msg_hit   = r_sealed && msg_cls.hit;
    assign o_stat.seal_last = (r_seal_idx == CELL_W'(CELLS - 1));
    assign o_stat.row_last  = (r_row_count == ROWCNT_W'(GRID_SIDE - 2));
    assign o_stat.beat_last = (r_beat == POS_W'(GRID_SIDE - 1));
    assign o_stat.out_free  = out_free;

    // select the source column for this beat; codes six and seven give zero
    always_comb begin
        src      = i_column_order[r_beat * POS_W +: POS_W];
        sym_idx  = '0;
        emit_sym = '0;
        if (src < POS_W'(GRID_SIDE)) begin
            sym_idx  = r_row_buf[src];
            emit_sym = i_symbol_letters[sym_idx * SYM_W +: SYM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[map_waddr] <= r_fill;
        end
        if (i_cmd.lookup) begin
            r_map_q <= r_map[msg_cls.idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_store) begin
            for (int j = 0; j < GRID_SIDE; j++) begin
                if (ROWCNT_W'(j) == r_row_count) begin
                    r_row_buf[j] <= grid_row(r_map_q);
                end
                if (ROWCNT_W'(j) == r_row_count + ROWCNT_W'(1)) begin
                    r_row_buf[j] <= grid_col(r_map_q);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= '0;
            r_fill      <= '0;
            r_sealed    <= 1'b0;
            r_seal_idx  <= '0;
            r_row_count <= '0;
            r_beat      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_seen   <= '0;
                r_fill   <= '0;
                r_sealed <= 1'b0;
            end
            if (key_new) begin
                r_seen[key_cls.idx] <= 1'b1;
                r_fill              <= r_fill + CELL_W'(1);
            end
            if (i_cmd.seal_step) begin
                if (seal_new) begin
                    r_seen[r_seal_idx] <= 1'b1;
                    r_fill             <= r_fill + CELL_W'(1);
                end
                if (o_stat.seal_last) begin
                    r_seal_idx <= '0;
                    r_sealed   <= 1'b1;
                end else begin
                    r_seal_idx <= r_seal_idx + CELL_W'(1);
                end
            end
            if (i_cmd.row_store) begin
                // a full row empties the count; contents hold for emission
                r_row_count <= o_stat.row_last ? '0 : r_row_count + ROWCNT_W'(2);
            end
            if (i_cmd.emit_beat) begin
                r_beat <= o_stat.beat_last ? '0 : r_beat + POS_W'(1);
            end
            if (i_cmd.emit_beat || i_cmd.err_beat) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_beat) begin
            r_symbol   <= emit_sym;
            r_last     <= o_stat.beat_last;
            r_bad_char <= 1'b0;
        end else if (i_cmd.err_beat) begin
            r_symbol   <= '0;
            r_last     <= 1'b1;
            r_bad_char <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_symbol    = r_symbol;
    assign o_last      = r_last;
    assign o_bad_char  = r_bad_char;

endmodule

>>> rtl/core/adfgvx_cipher_encoder_unit.sv
// ----------------------------------------------------------------------------
// adfgvx_cipher_encoder_unit
// ADFGVX encoder: builds a 6x6 square from key beats and turns message
// characters into transposed substitution symbols.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries i_mode and i_char_code.
// Output channel (o_out_valid / i_out_stall) carries o_symbol, o_last and
// o_bad_char. The configuration channel (i_cfg_valid / o_cfg_ready) writes
// the symbol letters (index 0) or the column order (index 1); ready is
// always high and writes are expected only while the block is idle.
// A seal beat sweeps all 36 character classes, one per cycle, keeping the
// block busy until the sweep ends. A message beat is accepted together
// with the position map read; row and column are buffered in the next
// cycle. Every third found character then emits six beats through the
// single output register, one per cycle when the receiver does not stall.
// A character that is missing or arrives before sealing gives one error
// beat. Results wait in the output register while i_out_stall is high and
// the sequencer holds until it is free.
// Synchronous reset restores the default configuration, clears the seen
// flags, fill count, seal flag and row count; no clearing pass is needed.
// ----------------------------------------------------------------------------
module adfgvx_cipher_encoder_unit
    import adfgvx_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_mode,
    input  logic [SYM_W-1:0]     i_char_code,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [SYM_W-1:0]     o_symbol,
    output logic                 o_last,
    output logic                 o_bad_char,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [LETTERS_W-1:0] i_cfg_data
);

    logic [LETTERS_W-1:0] r_symbol_letters;
    logic [ORDER_W-1:0]   r_column_order;
    t_dp_cmd              cmd;
    t_dp_stat             stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_letters <= SYMBOL_LETTERS_RST;
            r_column_order   <= COLUMN_ORDER_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SYMBOL_LETTERS: r_symbol_letters <= i_cfg_data;
                CFG_COLUMN_ORDER:   r_column_order   <= i_cfg_data[ORDER_W-1:0];
                default:            r_column_order   <= r_column_order;
            endcase
        end
    end

    adfgvx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    adfgvx_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_char_code      (i_char_code),
        .i_symbol_letters (r_symbol_letters),
        .i_column_order   (r_column_order),
        .i_out_stall      (i_out_stall),
        .o_stat           (stat),
        .o_out_valid      (o_out_valid),
        .o_symbol         (o_symbol),
        .o_last           (o_last),
        .o_bad_char       (o_bad_char)
    );

endmodule
